FILE: hdl/clbw_pkg.sv
// Package for the character-cell bitmap line writer.
// Holds channel payload types, codes, sizing constants and the pixel rule.
// No dependencies; clbw_front, clbw_out_fifo, the top level and the testbench import it.
package clbw_pkg;

    localparam int VIEW_WIDTH_DEF  = 320;
    localparam int VIEW_HEIGHT_DEF = 200;

    localparam int COORD_W    = 16;
    localparam int ADDR_OUT_W = 13;
    localparam int CFG_IDX_W  = 2;

    // Result queue sizing. The depth is a power of two so the pointers wrap by themselves.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;

    localparam logic [COORD_W-1:0] COL_MAX = 16'hffff;

    typedef struct packed {
        logic                  op;
        logic [COORD_W-1:0]    line_x;
        logic [COORD_W-1:0]    line_y;
        logic [7:0]            pixel_value;
        logic                  first_of_line;
        logic [ADDR_OUT_W-1:0] read_address;
    } clbw_req_t;

    typedef struct packed {
        logic [ADDR_OUT_W-1:0] byte_address;
        logic [7:0]            byte_value;
        logic                  wrote;
        logic                  clipped;
    } clbw_rsp_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [COORD_W-1:0]   value;
    } clbw_cfg_t;

    // Item after coordinate translation, as it leaves the front end.
    typedef struct packed {
        logic                  valid;
        logic                  op;
        logic                  pix_on;
        logic [COORD_W-1:0]    dx;
        logic [COORD_W-1:0]    dy;
        logic [COORD_W:0]      px;
        logic [ADDR_OUT_W-1:0] raddr;
    } clbw_stage_t;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } clbw_state_t;

    // A source byte lights the pixel when bits 5 and 2 are both clear.
    function automatic logic pixel_on(input logic [7:0] v);
        return !v[5] && !v[2];
    endfunction

endpackage

FILE: hdl/clbw_stream_if.sv
// Valid/ready channel used for requests, results and configuration writes.
// The payload type is a parameter; the types come from clbw_pkg.
interface clbw_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/clbw_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// A read of the address being written returns the old contents. No dependencies.
module clbw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/clbw_front.sv
// Front end: viewport translation and column tracking for accepted items.
// Registers the translated item into the first pipeline stage. Uses clbw_pkg.
module clbw_front
    import clbw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  clbw_req_t          req,
    input  logic [COORD_W-1:0] origin_x,
    input  logic [COORD_W-1:0] origin_y,
    output clbw_stage_t        stage
);

    logic [COORD_W-1:0]    col_reg, col_next;
    logic [COORD_W-1:0]    col_use;
    logic                  valid_reg;
    logic                  op_reg;
    logic                  on_reg;
    logic [COORD_W-1:0]    dx_reg, dy_reg;
    logic [COORD_W:0]      px_reg;
    logic [ADDR_OUT_W-1:0] raddr_reg;
    logic [COORD_W-1:0]    dx, dy;

    always_comb
    begin
        col_use  = req.first_of_line ? '0 : col_reg;
        dx       = req.line_x - origin_x;
        dy       = req.line_y - origin_y;
        col_next = col_reg;
        if (accept && req.op == OP_DRAW)
        begin
            // The column index saturates instead of wrapping.
            col_next = (col_use < COL_MAX) ? col_use + 1'b1 : col_use;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= req.op;
            on_reg    <= pixel_on(req.pixel_value);
            dx_reg    <= dx;
            dy_reg    <= dy;
            px_reg    <= {1'b0, dx} + {1'b0, col_use};
            raddr_reg <= req.read_address;
        end
    end

    assign stage = '{valid:  valid_reg,
                     op:     op_reg,
                     pix_on: on_reg,
                     dx:     dx_reg,
                     dy:     dy_reg,
                     px:     px_reg,
                     raddr:  raddr_reg};

endmodule

FILE: hdl/clbw_out_fifo.sv
// Small result queue between the write-back stage and the result channel.
// Reports its fill level so the top level can reserve room. Uses clbw_pkg.
module clbw_out_fifo
    import clbw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  clbw_rsp_t            push_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output clbw_rsp_t            out_data,
    output logic [OUT_CNT_W-1:0] count
);

    clbw_rsp_t             entries [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [OUT_CNT_W-1:0]  count_reg;
    logic                  pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = entries[rd_ptr_reg];
    assign count     = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hdl/cell_bitmap_pixel_line_writer_top.sv
// Character-cell bitmap line writer, top level. Uses clbw_pkg, clbw_stream_if, clbw_ram,
// clbw_front and clbw_out_fifo.
// Throughput: one request per cycle, while no clearing pass runs and the result queue has
// room, set by the single read-modify-write pass per pixel through the bitmap RAM, with
// the freshly written byte forwarded to the next access.
// Reset: control registers other than the state go to zero, then a clearing pass writes zero
// to every bitmap byte, one byte per cycle, ((VIEW_HEIGHT+7)/8)*VIEW_WIDTH+8 bytes (8008 at 320x200).
module cell_bitmap_pixel_line_writer_top
    import clbw_pkg::*;
#(
    parameter int VIEW_WIDTH  = VIEW_WIDTH_DEF,
    parameter int VIEW_HEIGHT = VIEW_HEIGHT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    clbw_stream_if.sink   req,
    clbw_stream_if.source rsp,
    clbw_stream_if.sink   cfg
);

    // The store has one spare cell's worth of slack (8 bytes) past the last row of cells.
    localparam int STORE_BYTES = ((VIEW_HEIGHT + 7) / 8) * VIEW_WIDTH + 8;
    localparam int AW          = $clog2(STORE_BYTES);

    // ------------------------------------------------------------------
    // Configuration registers. The user must write them only while the block is idle; the
    // block itself does not enforce this. Writes are always taken.
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] origin_x_reg, origin_y_reg;
    clbw_cfg_t          cfg_data;

    assign cfg.ready = 1'b1;
    assign cfg_data  = cfg.data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg_data.index)
                CFG_ORIGIN_X: origin_x_reg <= cfg_data.value;
                CFG_ORIGIN_Y: origin_y_reg <= cfg_data.value;
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Clearing pass after reset. While it runs, the RAM write port belongs
    // to the sweep and no request transaction is accepted.
    // ------------------------------------------------------------------
    clbw_state_t   state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          clearing;

    assign clearing = (state_reg == ST_CLEAR);

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(STORE_BYTES - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                clr_cnt_next = clr_cnt_reg;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Admission. Every item in flight has a slot reserved in the result
    // queue, so the pipeline never has to stall once an item is in.
    // ------------------------------------------------------------------
    clbw_stage_t          s1;
    logic                 s2_valid_reg;
    logic [OUT_CNT_W-1:0] fifo_count;
    logic [OUT_CNT_W-1:0] in_flight;
    logic                 req_accept;

    assign in_flight  = fifo_count + OUT_CNT_W'(s1.valid) + OUT_CNT_W'(s2_valid_reg);
    assign req.ready  = !clearing && (in_flight < OUT_CNT_W'(OUT_DEPTH));
    assign req_accept = req.valid && req.ready;

    // Stage 0 to stage 1: viewport translation and the running column index.
    clbw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (req_accept),
        .req      (req.data),
        .origin_x (origin_x_reg),
        .origin_y (origin_y_reg),
        .stage    (s1)
    );

    // ------------------------------------------------------------------
    // Stage 1: clip test, cell address and bit mask, and the RAM read.
    // ------------------------------------------------------------------
    logic          s1_clip;
    logic          s1_in_range;
    logic [AW-1:0] s1_draw_addr;
    logic [AW-1:0] s1_ram_addr;
    logic [7:0]    s1_mask;
    logic          s1_fwd_hit;

    // Stage 2 signals used by the forwarding compare.
    logic          s2_op_reg;
    logic          s2_clip_reg;
    logic          s2_oob_reg;
    logic          s2_on_reg;
    logic [7:0]    s2_mask_reg;
    logic [AW-1:0] s2_addr_reg;
    logic [ADDR_OUT_W-1:0] s2_raddr_reg;
    logic          s2_fwd_hit_reg;
    logic [7:0]    s2_fwd_data_reg;
    logic          s2_we;
    logic [7:0]    s2_cur;
    logic [7:0]    s2_new;
    logic [7:0]    ram_rdata;

    always_comb
    begin
        // A pixel is dropped when its row is off the viewport, when the line starts
        // off to the side, or when it runs past the right edge.
        s1_clip = (s1.dy >= COORD_W'(VIEW_HEIGHT)) ||
                  (s1.dx >= COORD_W'(VIEW_WIDTH)) ||
                  (s1.px >= (COORD_W + 1)'(VIEW_WIDTH));
        // Byte address: cell row times line width, plus the cell's column, plus the
        // row within the cell.
        s1_draw_addr = AW'(s1.dy >> 3) * AW'(VIEW_WIDTH) +
                       AW'({s1.px[COORD_W:3], 3'b000}) + AW'(s1.dy[2:0]);
        s1_in_range  = (32'(s1.raddr) < 32'(STORE_BYTES));
        s1_ram_addr  = (s1.op == OP_READ) ? AW'(32'(s1.raddr)) : s1_draw_addr;
        s1_mask      = 8'h80 >> s1.px[2:0];
        // The RAM returns the old byte when stage 2 writes the same address in this
        // cycle, so the new byte is carried across instead.
        s1_fwd_hit   = s1.valid && s2_we && (s1_ram_addr == s2_addr_reg);
    end

    // ------------------------------------------------------------------
    // Stage 2: modify the byte, write it back and hand the result to the queue.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1.valid)
        begin
            s2_op_reg       <= s1.op;
            s2_clip_reg     <= s1_clip;
            s2_oob_reg      <= !s1_in_range;
            s2_on_reg       <= s1.pix_on;
            s2_mask_reg     <= s1_mask;
            s2_addr_reg     <= s1_ram_addr;
            s2_raddr_reg    <= s1.raddr;
            s2_fwd_hit_reg  <= s1_fwd_hit;
            s2_fwd_data_reg <= s2_new;
        end
    end

    assign s2_we  = s2_valid_reg && (s2_op_reg == OP_DRAW) && !s2_clip_reg;
    assign s2_cur = s2_fwd_hit_reg ? s2_fwd_data_reg : ram_rdata;
    assign s2_new = s2_on_reg ? (s2_cur | s2_mask_reg) : (s2_cur & ~s2_mask_reg);

    // Bitmap store. The clearing sweep owns the write port until it finishes.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;

    assign ram_we    = clearing || s2_we;
    assign ram_waddr = clearing ? clr_cnt_reg : s2_addr_reg;
    assign ram_wdata = clearing ? 8'h00 : s2_new;

    clbw_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (s1_ram_addr),
        .rdata (ram_rdata)
    );

    // Result formation.
    clbw_rsp_t   s2_rsp;
    logic [31:0] s2_addr_ext;

    assign s2_addr_ext = 32'(s2_addr_reg);

    always_comb
    begin
        s2_rsp = '0;
        if (s2_op_reg == OP_READ)
        begin
            s2_rsp.byte_address = s2_raddr_reg;
            s2_rsp.byte_value   = s2_oob_reg ? 8'h00 : s2_cur;
        end
        else if (s2_clip_reg)
        begin
            s2_rsp.clipped = 1'b1;
        end
        else
        begin
            s2_rsp.byte_address = s2_addr_ext[ADDR_OUT_W-1:0];
            s2_rsp.byte_value   = s2_new;
            s2_rsp.wrote        = 1'b1;
        end
    end

    // Result queue: the output side may stall freely without holding up stage 2.
    clbw_rsp_t rsp_data;

    clbw_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_valid_reg),
        .push_data (s2_rsp),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (rsp_data),
        .count     (fifo_count)
    );

    assign rsp.data = rsp_data;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The slot reservation must keep the queue from overflowing.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (fifo_count < OUT_CNT_W'(OUT_DEPTH)))
        else $error("result queue pushed while full");

    // A draw write always lands inside the bitmap store.
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_we |-> (32'(s2_addr_reg) < 32'(STORE_BYTES)))
        else $error("bitmap write outside the store");

    // Nothing is in the pipeline while the clearing sweep owns the RAM.
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> (!s1.valid && !s2_valid_reg))
        else $error("item in flight during the clearing pass");

    // An offered result never claims both a write and a drop.
    a_rsp_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp_data.wrote && rsp_data.clipped))
        else $error("result marked both written and clipped");

endmodule

FILE: test/cell_bitmap_pixel_line_writer_top_test.sv
// Self-checking testbench for cell_bitmap_pixel_line_writer_top.
// Depends on clbw_pkg and clbw_stream_if. A shadow copy of the cell bitmap predicts every
// result, and each result leaving the block is checked in order against that prediction.
module cell_bitmap_pixel_line_writer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import clbw_pkg::*;

    localparam int VW          = VIEW_WIDTH_DEF;
    localparam int VH          = VIEW_HEIGHT_DEF;
    localparam int STORE_BYTES = ((VH + 7) / 8) * VW + 8;

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 88;

    logic clk;
    logic rst_n;

    clbw_stream_if #(.payload_t(clbw_req_t)) req_if ();
    clbw_stream_if #(.payload_t(clbw_rsp_t)) rsp_if ();
    clbw_stream_if #(.payload_t(clbw_cfg_t)) cfg_if ();

    cell_bitmap_pixel_line_writer_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    // Shadow state of the block: the viewport origin, the column counter of the line in
    // progress, and the bitmap itself.
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [COORD_W-1:0] column_pos;
    logic [7:0]         shadow_bitmap [STORE_BYTES];

    // Pixel and read transactions waiting to be offered, and the results owed by the block.
    clbw_req_t pixel_jobs[$];
    clbw_rsp_t bitmap_results_due[$];

    // When low, neither side inserts gaps or stalls.
    bit idle_on;
    bit req_taken;
    int unsigned send_gap;
    int unsigned sink_stall;

    int mismatch_count;
    int n_written;
    int n_clipped;
    int n_reads;
    int n_origin_writes;
    int items_queued;

    // Address of the first pixel of the most recent well-formed line; reads aim there so
    // that freshly written bytes are read back.
    int unsigned recent_line_addr;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Applies one accepted transaction to the shadow state and returns the result the
    // block owes for it. Draws update the column counter and, when inside the viewport,
    // the shadow bitmap.
    function automatic clbw_rsp_t predict_bitmap_access(input clbw_req_t it);
        clbw_rsp_t          r;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        logic [COORD_W:0]   px;
        int unsigned        cell_addr;
        logic [7:0]         mask;
        logic [7:0]         b;
        r = '0;
        if (it.op == OP_READ)
        begin
            n_reads++;
            r.byte_address = it.read_address;
            r.byte_value   = (it.read_address < STORE_BYTES) ? shadow_bitmap[it.read_address]
                                                             : 8'h00;
            return r;
        end
        if (it.first_of_line)
            column_pos = '0;
        dx = it.line_x - origin_x;
        dy = it.line_y - origin_y;
        px = {1'b0, dx} + {1'b0, column_pos};
        // The counter stops at its ceiling rather than wrapping back to column zero.
        if (column_pos != COL_MAX)
            column_pos++;
        if (dy >= VH || dx >= VW || px >= VW)
        begin
            n_clipped++;
            r.clipped = 1'b1;
            return r;
        end
        // Cells are 8x8: eight consecutive bytes hold the eight rows of one cell, and the
        // leftmost pixel of the cell sits in bit 7.
        cell_addr = dy[15:3] * VW + {px[16:3], 3'b000} + dy[2:0];
        mask      = 8'h80 >> px[2:0];
        b         = shadow_bitmap[cell_addr];
        if (!it.pixel_value[5] && !it.pixel_value[2])
            b = b | mask;
        else
            b = b & ~mask;
        shadow_bitmap[cell_addr] = b;
        n_written++;
        r.byte_address = cell_addr[ADDR_OUT_W-1:0];
        r.byte_value   = b;
        r.wrote        = 1'b1;
        return r;
    endfunction

    function automatic clbw_req_t random_item();
        clbw_req_t it;
        it.op            = OP_DRAW;
        it.line_x        = COORD_W'($urandom);
        it.line_y        = COORD_W'($urandom);
        it.pixel_value   = 8'($urandom);
        it.first_of_line = 1'($urandom_range(0, 1));
        it.read_address  = ADDR_OUT_W'($urandom);
        return it;
    endfunction

    task automatic queue_read(input int unsigned addr);
        clbw_req_t it;
        it              = random_item();
        it.op           = OP_READ;
        it.read_address = addr[ADDR_OUT_W-1:0];
        pixel_jobs.push_back(it);
        items_queued++;
    endtask

    task automatic queue_draw(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic [7:0] pv, input logic first);
        clbw_req_t it;
        it               = random_item();
        it.line_x        = x;
        it.line_y        = y;
        it.pixel_value   = pv;
        it.first_of_line = first;
        pixel_jobs.push_back(it);
        items_queued++;
    endtask

    // A whole line with random pixel bytes. Now and then a read is slipped in mid-line;
    // it must leave the column counter alone.
    task automatic queue_line(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input int len);
        for (int i = 0; i < len; i++)
        begin
            queue_draw(x, y, 8'($urandom), i == 0);
            if (i != 0 && $urandom_range(0, 11) == 0)
                queue_read(recent_line_addr);
        end
    endtask

    // Returns once every queued transaction went in and every owed result came out.
    task automatic wait_drain();
        @(posedge clk);
        while (pixel_jobs.size() != 0 || req_if.valid || bitmap_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_origin(input logic [CFG_IDX_W-1:0] idx,
                                input logic [COORD_W-1:0] value);
        clbw_cfg_t w;
        w.index = idx;
        w.value = value;
        @(negedge clk);
        cfg_if.data  <= w;
        cfg_if.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        if (idx == CFG_ORIGIN_X)
            origin_x = value;
        else
            origin_y = value;
        n_origin_writes++;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic note_mismatch(input string what, input clbw_rsp_t exp_r,
                                 input clbw_rsp_t got_r);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t mismatch (%s): expected addr=%0d val=%02h wrote=%0b clipped=%0b",
                     $realtime, what, exp_r.byte_address, exp_r.byte_value, exp_r.wrote,
                     exp_r.clipped);
            $display("    got addr=%0d val=%02h wrote=%0b clipped=%0b",
                     got_r.byte_address, got_r.byte_value, got_r.wrote, got_r.clipped);
        end
    endtask

    // Request driver. A transaction stays on the channel until it is taken; after each
    // one the next gap is drawn, so gaps fall between every kind of item.
    always @(negedge clk)
    begin
        if (rst_n && (!req_if.valid || req_taken))
        begin
            if (send_gap != 0)
            begin
                send_gap--;
                req_if.valid <= 1'b0;
            end
            else if (pixel_jobs.size() != 0)
            begin
                req_if.data  <= pixel_jobs.pop_front();
                req_if.valid <= 1'b1;
                send_gap = pick_gap();
            end
            else
                req_if.valid <= 1'b0;
        end
    end

    // Result back-pressure: stalls of random length between single ready cycles.
    always @(negedge clk)
    begin
        if (sink_stall != 0)
        begin
            sink_stall--;
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            rsp_if.ready <= 1'b1;
            sink_stall = pick_gap();
        end
    end

    // Monitor. Every accepted request is predicted at once, in acceptance order, and
    // every accepted result is compared with the oldest prediction.
    always @(posedge clk)
    begin
        clbw_rsp_t exp_r;
        clbw_rsp_t got_r;
        if (rst_n)
        begin
            req_taken = req_if.valid && req_if.ready;
            if (req_taken)
                bitmap_results_due.push_back(predict_bitmap_access(req_if.data));
            if (rsp_if.valid && rsp_if.ready)
            begin
                got_r = rsp_if.data;
                if (bitmap_results_due.size() == 0)
                    note_mismatch("result with nothing outstanding", '0, got_r);
                else
                begin
                    exp_r = bitmap_results_due.pop_front();
                    if (got_r.byte_address !== exp_r.byte_address
                        || got_r.byte_value !== exp_r.byte_value
                        || got_r.wrote !== exp_r.wrote
                        || got_r.clipped !== exp_r.clipped)
                        note_mismatch("field", exp_r, got_r);
                end
            end
        end
    end

    // Main sequence: reset, a directed set of corner cases, then random phases under
    // different viewport origins.
    initial
    begin
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
        int unsigned        dx;
        int unsigned        dy;
        int unsigned        r;
        int                 len;
        clbw_req_t          it;

        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        rst_n        = 1'b0;
        origin_x     = '0;
        origin_y     = '0;
        column_pos   = '0;
        foreach (shadow_bitmap[i])
            shadow_bitmap[i] = 8'h00;
        idle_on          = 1'b1;
        req_taken        = 1'b0;
        send_gap         = 0;
        sink_stall       = 0;
        mismatch_count   = 0;
        n_written        = 0;
        n_clipped        = 0;
        n_reads          = 0;
        n_origin_writes  = 0;
        items_queued     = 0;
        recent_line_addr = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, origin at zero. The bitmap must read back as zero after reset.
        queue_read(0);
        // Pixel rule: only bytes with bits 5 and 2 both clear light the pixel.
        queue_draw(16'd0, 16'd0, 8'h00, 1'b1);
        queue_draw(16'd0, 16'd0, 8'hdb, 1'b0);
        queue_draw(16'd0, 16'd0, 8'h20, 1'b0);
        queue_draw(16'd0, 16'd0, 8'h04, 1'b0);
        // A read in mid-line keeps the column counter.
        queue_read(0);
        queue_draw(16'd0, 16'd0, 8'hff, 1'b0);
        queue_draw(16'd0, 16'd0, 8'h00, 1'b0);
        // Bottom-right corner, then one step past the right edge.
        queue_draw(16'd319, 16'd199, 8'h00, 1'b1);
        queue_draw(16'd319, 16'd199, 8'h00, 1'b0);
        // Lines starting below, right of, left of and above the viewport are dropped whole.
        queue_draw(16'd0, 16'd200, 8'h00, 1'b1);
        queue_draw(16'd320, 16'd0, 8'h00, 1'b1);
        queue_draw(16'hffff, 16'd0, 8'h00, 1'b1);
        queue_draw(16'd0, 16'hffff, 8'h00, 1'b1);
        // Last cell of the top row, filled to its right edge and beyond.
        queue_draw(16'd316, 16'd7, 8'h00, 1'b1);
        queue_draw(16'd316, 16'd7, 8'h00, 1'b0);
        queue_draw(16'd316, 16'd7, 8'h00, 1'b0);
        queue_draw(16'd316, 16'd7, 8'h00, 1'b0);
        queue_draw(16'd316, 16'd7, 8'h00, 1'b0);
        // Reads at the end of the store and past it.
        queue_read(319);
        queue_read(8004);
        queue_read(STORE_BYTES - 1);
        queue_read(STORE_BYTES);
        queue_read(8191);
        wait_drain();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       begin ox = 16'hffff; oy = 16'hffff; end
                1:       begin ox = 16'h8000; oy = 16'h7fff; end
                2:       begin ox = 16'h0000; oy = 16'h0000; end
                default: begin ox = COORD_W'($urandom); oy = COORD_W'($urandom); end
            endcase
            write_origin(CFG_ORIGIN_X, ox);
            write_origin(CFG_ORIGIN_Y, oy);
            // Two phases run with both sides at full speed.
            idle_on      = (phase != 3 && phase != 6);
            items_queued = 0;
            while (items_queued < PHASE_ITEMS)
            begin
                r = $urandom_range(0, 99);
                if (r < 68)
                begin
                    // Well-formed line starting inside the viewport; long ones may run off
                    // the right edge. Starts near the edges are favored.
                    case ($urandom_range(0, 3))
                        0:       dx = $urandom_range(VW - 16, VW - 1);
                        1:       dx = $urandom_range(0, 15);
                        default: dx = $urandom_range(0, VW - 1);
                    endcase
                    dy  = ($urandom_range(0, 4) == 0) ? $urandom_range(VH - 8, VH - 1)
                                                      : $urandom_range(0, VH - 1);
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 12);
                    recent_line_addr = (dy / 8) * VW + (dx & ~7) + (dy % 8);
                    queue_line(ox + dx[COORD_W-1:0], oy + dy[COORD_W-1:0], len);
                end
                else if (r < 84)
                begin
                    case ($urandom_range(0, 9))
                        0:       queue_read($urandom_range(STORE_BYTES, 8191));
                        1, 2:    queue_read($urandom_range(0, STORE_BYTES - 1));
                        default: queue_read(recent_line_addr + $urandom_range(0, 7));
                    endcase
                end
                else
                begin
                    // Noise: stray continuations, starts just outside the viewport, or
                    // anything at all.
                    it = random_item();
                    case ($urandom_range(0, 3))
                        0: it.line_x = COORD_W'(ox + $urandom_range(VW, VW + 12));
                        1: it.line_x = COORD_W'(ox - $urandom_range(1, 8));
                        2: it.line_y = COORD_W'(oy + $urandom_range(VH, VH + 12));
                        default: it.op = 1'($urandom_range(0, 1));
                    endcase
                    pixel_jobs.push_back(it);
                    items_queued++;
                end
            end
            wait_drain();
        end

        repeat (20) @(posedge clk);
        if (bitmap_results_due.size() != 0)
        begin
            $display("%0d results never arrived", bitmap_results_due.size());
            mismatch_count += bitmap_results_due.size();
        end
        $display("Coverage: %0d pixels written, %0d pixels dropped, %0d byte reads",
                 n_written, n_clipped, n_reads);
        $display("across %0d origin register writes, with edge, wrap and clip cases",
                 n_origin_writes);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, clearing pass included.
    initial
    begin
        #20_000_000;
        $display("Run timed out");
        $display("CHECK FAILED");
        $finish;
    end

endmodule
